// File: hdl/cdq_pkg.sv
package cdq_pkg;

   // Deque depth and stored item width.
   localparam int CAPACITY = 16;
   localparam int ITEM_WIDTH = 32;

   // Fixed field widths of the request and response beats.
   localparam int DATA_WIDTH = 32;
   localparam int POS_WIDTH = 4;
   localparam int COUNT_WIDTH = 5;
   localparam int OP_WIDTH = 3;
   localparam int STATUS_WIDTH = 2;

   // Items arrive on a 32-bit field, so no more than that is ever kept.
   localparam int STORE_WIDTH = (ITEM_WIDTH < DATA_WIDTH) ? ITEM_WIDTH : DATA_WIDTH;
   localparam int IDX_WIDTH = $clog2(CAPACITY);
   localparam int OCC_WIDTH = $clog2(CAPACITY + 1);
   localparam int CMP_WIDTH = (POS_WIDTH > OCC_WIDTH) ? POS_WIDTH : OCC_WIDTH;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_READ_AT    = 3'd4,
      OP_REMOVE_AT  = 3'd5
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // Per-cell move controls: load the new item, take the lower
   // neighbor's value, or take the upper neighbor's value.
   typedef struct packed {
      logic load;
      logic take_lower;
      logic take_upper;
   } cell_ctrl_type;

endpackage

// File: hdl/cdq_cell.sv
module cdq_cell (
   input  logic                                  clock,
   input  cdq_pkg::cell_ctrl_type                ctrl,
   input  logic [cdq_pkg::STORE_WIDTH-1:0]       load_data,
   input  logic [cdq_pkg::STORE_WIDTH-1:0]       lower_data,
   input  logic [cdq_pkg::STORE_WIDTH-1:0]       upper_data,
   output logic [cdq_pkg::STORE_WIDTH-1:0]       data_q
);

   logic [cdq_pkg::STORE_WIDTH-1:0] data_ff;
   logic [cdq_pkg::STORE_WIDTH-1:0] data_in;

   // At most one control is set in a cycle; otherwise the cell holds.
   always_comb begin
      priority if (ctrl.load) begin
         data_in = load_data;
      end else if (ctrl.take_lower) begin
         data_in = lower_data;
      end else if (ctrl.take_upper) begin
         data_in = upper_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule

// File: hdl/circular_deque_engine_top.sv
// Double-ended queue built as a row of shifting cells.
// A response beat appears in the cycle after its request beat is accepted.
// One request per cycle unless rsp_tready stalls; every operation is one cell update.
// Reset: synchronous, active high; clears the count and the output valid.
// Cell contents are not reset, and a cell above the count is never read.
module circular_deque_engine_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] data_in, [35:32] position, [39:36] zero
   input  logic [2:0]  req_tuser,   // [2:0] operation

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] data_out, [36:32] count_after, [39:37] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int CAP = cdq_pkg::CAPACITY;

   // Cell i always holds the entry at position i counted from the back,
   // so the circular back pointer of a software deque is never needed:
   // pushing or popping at the back shifts the whole row by one cell, and
   // removing an entry shifts every cell at or above it down by one.

   logic                              fire;
   logic [cdq_pkg::OCC_WIDTH-1:0]     occ_ff;
   logic [cdq_pkg::OCC_WIDTH-1:0]     occ_in;

   logic                              rsp_valid_ff;
   logic [cdq_pkg::DATA_WIDTH-1:0]    rsp_data_ff;
   logic [cdq_pkg::OCC_WIDTH-1:0]     rsp_count_ff;
   cdq_pkg::status_type               rsp_status_ff;

   logic [cdq_pkg::OP_WIDTH-1:0]      op_raw;
   logic [cdq_pkg::DATA_WIDTH-1:0]    item_raw;
   logic [cdq_pkg::POS_WIDTH-1:0]     pos_raw;
   logic [cdq_pkg::STORE_WIDTH-1:0]   item;
   logic [cdq_pkg::IDX_WIDTH-1:0]     pos_idx;
   logic [cdq_pkg::IDX_WIDTH-1:0]     top_idx;
   logic [cdq_pkg::IDX_WIDTH-1:0]     front_idx;
   logic [cdq_pkg::IDX_WIDTH-1:0]     rd_idx;

   logic                              is_full;
   logic                              is_empty;
   logic                              in_range;

   logic                              do_load;
   logic                              do_up;
   logic                              do_down;
   logic                              do_remove;
   logic                              has_data;
   cdq_pkg::status_type               status;

   logic [cdq_pkg::STORE_WIDTH-1:0]   cell_q [CAP];
   cdq_pkg::cell_ctrl_type            cell_ctrl [CAP];

   // The output register parts the two sides: a new request is taken
   // whenever the held response is gone or leaves in this same cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire = req_tvalid && req_tready;

   assign op_raw = req_tuser;
   assign item_raw = req_tdata[31:0];
   assign pos_raw = req_tdata[35:32];
   assign item = cdq_pkg::STORE_WIDTH'(item_raw);

   assign is_full = (occ_ff == cdq_pkg::OCC_WIDTH'(CAP));
   assign is_empty = (occ_ff == '0);
   assign in_range = (cdq_pkg::CMP_WIDTH'(pos_raw) < cdq_pkg::CMP_WIDTH'(occ_ff));

   // The index casts only matter for cells that exist: a push at the front
   // is never done on a full row, and a pop at the front never on an empty one.
   assign pos_idx = cdq_pkg::IDX_WIDTH'(pos_raw);
   assign top_idx = cdq_pkg::IDX_WIDTH'(occ_ff);
   assign front_idx = cdq_pkg::IDX_WIDTH'(occ_ff - 1'b1);

   // Decode the request into row moves, a read index, a status and the
   // new count.
   always_comb begin
      do_load = 1'b0;
      do_up = 1'b0;
      do_down = 1'b0;
      do_remove = 1'b0;
      has_data = 1'b0;
      rd_idx = pos_idx;
      status = cdq_pkg::ST_OK;
      occ_in = occ_ff;
      unique case (op_raw)
         cdq_pkg::OP_PUSH_FRONT: begin
            if (is_full) begin
               status = cdq_pkg::ST_FULL;
            end else begin
               do_load = 1'b1;
               occ_in = occ_ff + 1'b1;
            end
         end
         cdq_pkg::OP_PUSH_BACK: begin
            if (is_full) begin
               status = cdq_pkg::ST_FULL;
            end else begin
               do_up = 1'b1;
               occ_in = occ_ff + 1'b1;
            end
         end
         cdq_pkg::OP_POP_FRONT: begin
            rd_idx = front_idx;
            if (is_empty) begin
               status = cdq_pkg::ST_EMPTY;
            end else begin
               has_data = 1'b1;
               occ_in = occ_ff - 1'b1;
            end
         end
         cdq_pkg::OP_POP_BACK: begin
            rd_idx = '0;
            if (is_empty) begin
               status = cdq_pkg::ST_EMPTY;
            end else begin
               has_data = 1'b1;
               do_down = 1'b1;
               occ_in = occ_ff - 1'b1;
            end
         end
         cdq_pkg::OP_READ_AT: begin
            if (!in_range) begin
               status = cdq_pkg::ST_RANGE;
            end else begin
               has_data = 1'b1;
            end
         end
         cdq_pkg::OP_REMOVE_AT: begin
            if (!in_range) begin
               status = cdq_pkg::ST_RANGE;
            end else begin
               has_data = 1'b1;
               do_remove = 1'b1;
               occ_in = occ_ff - 1'b1;
            end
         end
         default: begin
            // Unused codes leave everything as it is and answer ok.
         end
      endcase
   end

   // Per-cell controls. Cells above the new count may take stale values;
   // they are never read before being written again.
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         cell_ctrl[i].load = fire && do_load && (cdq_pkg::IDX_WIDTH'(i) == top_idx);
         cell_ctrl[i].take_lower = fire && do_up;
         cell_ctrl[i].take_upper = fire &&
            (do_down || (do_remove && (cdq_pkg::IDX_WIDTH'(i) >= pos_idx)));
      end
   end

   // The row of cells: cell 0 takes the pushed item from below, and the
   // top cell feeds itself from above.
   for (genvar g = 0; g < CAP; g++) begin : g_cell
      logic [cdq_pkg::STORE_WIDTH-1:0] lower_data;
      logic [cdq_pkg::STORE_WIDTH-1:0] upper_data;

      if (g == 0) begin : g_bottom
         assign lower_data = item;
      end else begin : g_lower
         assign lower_data = cell_q[g-1];
      end

      if (g == CAP - 1) begin : g_top
         assign upper_data = cell_q[g];
      end else begin : g_upper
         assign upper_data = cell_q[g+1];
      end

      cdq_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[g]),
         .load_data  (item),
         .lower_data (lower_data),
         .upper_data (upper_data),
         .data_q     (cell_q[g])
      );
   end

   // Count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (fire) begin
         occ_ff <= occ_in;
      end
   end

   // Response register. Data is forced to zero unless the request
   // returned an entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= has_data ? cdq_pkg::DATA_WIDTH'(cell_q[rd_idx]) : '0;
         rsp_status_ff <= status;
         rsp_count_ff <= occ_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'b000, cdq_pkg::COUNT_WIDTH'(rsp_count_ff), rsp_data_ff};
   assign rsp_tuser = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= cdq_pkg::OCC_WIDTH'(CAP))
      else $error("occupancy above capacity");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("accepted request produced no response beat");

   a_occ_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(occ_ff))
      else $error("count changed without a request");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_count_ff == occ_ff))
      else $error("reported count differs from stored count");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != cdq_pkg::ST_OK)) |-> (rsp_data_ff == '0))
      else $error("error response carries data");
`endif

endmodule

// File: tb/tb_circular_deque_engine_top.sv
module tb_circular_deque_engine_top;

   // The two operation codes that the block treats as no-ops.
   localparam logic [cdq_pkg::OP_WIDTH-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [cdq_pkg::OP_WIDTH-1:0] OP_SPARE_HI = 3'd7;

   // Number of random requests that touch the deque, not counting no-ops.
   localparam int RANDOM_BEATS = 500;

   // Idling stops once this few requests are left in the backlog.
   localparam int QUIET_TAIL = 60;

   // One request beat as the driver presents it.
   typedef struct {
      logic [cdq_pkg::OP_WIDTH-1:0]   op;
      logic [cdq_pkg::DATA_WIDTH-1:0] data;
      logic [cdq_pkg::POS_WIDTH-1:0]  pos;
   } deque_request_type;

   // One response beat as the predictor expects it.
   typedef struct {
      logic [cdq_pkg::DATA_WIDTH-1:0]  data;
      cdq_pkg::status_type             status;
      logic [cdq_pkg::COUNT_WIDTH-1:0] count;
   } deque_answer_type;

   // Every input starts at a known value, with reset already asserted.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // [31:0] data_in, [35:32] position, [39:36] zero
   logic [2:0]  req_tuser = '0;   // [2:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [31:0] data_out, [36:32] count_after, [39:37] zero
   logic [1:0]  rsp_tuser;        // [1:0] status

   // Requests still waiting to be driven, and answers still waiting to arrive.
   deque_request_type request_backlog[$];
   deque_answer_type  pending_answers[$];

   // The predictor's own copy of the deque: a circular row of cells, the slot
   // of the back entry, and the number of stored items.
   logic [cdq_pkg::DATA_WIDTH-1:0]  deque_cells [cdq_pkg::CAPACITY];
   logic [cdq_pkg::IDX_WIDTH-1:0]   back_slot = '0;
   logic [cdq_pkg::COUNT_WIDTH-1:0] stored_count = '0;

   // Occupancy as seen while the stimulus is built, used only to steer
   // positions toward stored entries.
   int planned_count = 0;

   int error_count = 0;
   int sent_beats = 0;
   int req_gap = 0;
   int rsp_gap = 0;

   // Idling is allowed only in some stretches of the run, and never near its end.
   logic idle_ok = 1'b0;

   circular_deque_engine_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      error_count++;
   endtask

   // Appends a request to the backlog and follows the occupancy it leaves.
   task automatic queue_request(input logic [cdq_pkg::OP_WIDTH-1:0] op,
                                input logic [cdq_pkg::DATA_WIDTH-1:0] data,
                                input logic [cdq_pkg::POS_WIDTH-1:0] pos);
      deque_request_type beat;
      beat.op = op;
      beat.data = data;
      beat.pos = pos;
      request_backlog.push_back(beat);
      case (op)
         cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_BACK: begin
            if (planned_count < cdq_pkg::CAPACITY) planned_count++;
         end
         cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_BACK: begin
            if (planned_count > 0) planned_count--;
         end
         cdq_pkg::OP_REMOVE_AT: begin
            if (pos < planned_count) planned_count--;
         end
         default: ;
      endcase
   endtask

   // Applies one accepted request to the predictor's deque and queues the
   // answer it must produce. Position p lives at slot back_slot + p, and the
   // four-bit slot index wraps around the sixteen cells by itself.
   task automatic apply_request(input logic [cdq_pkg::OP_WIDTH-1:0] op,
                                input logic [cdq_pkg::DATA_WIDTH-1:0] data,
                                input logic [cdq_pkg::POS_WIDTH-1:0] pos);
      deque_answer_type answer;
      int i;
      answer.data = '0;
      answer.status = cdq_pkg::ST_OK;
      case (op)
         cdq_pkg::OP_PUSH_FRONT: begin
            if (stored_count >= cdq_pkg::CAPACITY) begin
               answer.status = cdq_pkg::ST_FULL;
            end else begin
               deque_cells[back_slot + stored_count[cdq_pkg::IDX_WIDTH-1:0]] = data;
               stored_count++;
            end
         end
         cdq_pkg::OP_PUSH_BACK: begin
            if (stored_count >= cdq_pkg::CAPACITY) begin
               answer.status = cdq_pkg::ST_FULL;
            end else begin
               back_slot--;
               deque_cells[back_slot] = data;
               stored_count++;
            end
         end
         cdq_pkg::OP_POP_FRONT: begin
            if (stored_count == 0) begin
               answer.status = cdq_pkg::ST_EMPTY;
            end else begin
               stored_count--;
               answer.data = deque_cells[back_slot + stored_count[cdq_pkg::IDX_WIDTH-1:0]];
            end
         end
         cdq_pkg::OP_POP_BACK: begin
            if (stored_count == 0) begin
               answer.status = cdq_pkg::ST_EMPTY;
            end else begin
               answer.data = deque_cells[back_slot];
               back_slot++;
               stored_count--;
            end
         end
         cdq_pkg::OP_READ_AT: begin
            if (pos >= stored_count) begin
               answer.status = cdq_pkg::ST_RANGE;
            end else begin
               answer.data = deque_cells[back_slot + pos];
            end
         end
         cdq_pkg::OP_REMOVE_AT: begin
            if (pos >= stored_count) begin
               answer.status = cdq_pkg::ST_RANGE;
            end else begin
               answer.data = deque_cells[back_slot + pos];
               // Entries above the hole slide one place toward the back.
               for (i = pos; i + 1 < stored_count; i++) begin
                  deque_cells[back_slot + cdq_pkg::IDX_WIDTH'(i)] =
                     deque_cells[back_slot + cdq_pkg::IDX_WIDTH'(i + 1)];
               end
               stored_count--;
            end
         end
         default: ;
      endcase
      answer.count = stored_count;
      pending_answers.push_back(answer);
   endtask

   // Request driver. A new beat is loaded only when no beat is on the bus or
   // the current one is taken at this edge, so tvalid never drops while a
   // beat waits. Random gaps fall between beats.
   always @(posedge clock) begin
      deque_request_type beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap--;
         end else if (request_backlog.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (idle_ok && $urandom_range(0, 5) == 0) begin
            req_tvalid <= 1'b0;
            req_gap = $urandom_range(0, 3);
         end else begin
            beat = request_backlog.pop_front();
            req_tdata <= {4'b0000, beat.pos, beat.data};
            req_tuser <= beat.op;
            req_tvalid <= 1'b1;
            sent_beats++;
         end
      end
      // Every third stretch of fifty beats runs without idling, and so does
      // the tail of the run.
      idle_ok <= ((sent_beats / 50) % 3 != 1) && (request_backlog.size() > QUIET_TAIL);
   end

   // Response ready, stalled in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap--;
      end else if (idle_ok && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         rsp_gap = $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor. Both handshakes are sampled at the clock edge, where the values
   // seen are the ones settled before the edge. The request is applied first
   // so that an answer in the same cycle as its request would still find its expectation.
   always @(posedge clock) begin
      deque_answer_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            apply_request(req_tuser, req_tdata[31:0], req_tdata[35:32]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_answers.size() == 0) begin
               report_mismatch("response beat with no request waiting for it");
            end else begin
               want = pending_answers.pop_front();
               if (rsp_tdata[31:0] !== want.data) begin
                  report_mismatch($sformatf("data_out %h, expected %h",
                                            rsp_tdata[31:0], want.data));
               end
               if (rsp_tuser !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_tuser, want.status));
               end
               if (rsp_tdata[36:32] !== want.count) begin
                  report_mismatch($sformatf("count_after %0d, expected %0d",
                                            rsp_tdata[36:32], want.count));
               end
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int i;
      int made;
      int pick;
      int phase;
      logic [cdq_pkg::OP_WIDTH-1:0]   op;
      logic [cdq_pkg::DATA_WIDTH-1:0] data;
      logic [cdq_pkg::POS_WIDTH-1:0]  pos;

      // Directed part. On the empty deque, both pops report empty, and a read
      // or a remove at any position is out of range. The spare codes do nothing.
      queue_request(cdq_pkg::OP_POP_FRONT, 32'hFFFF_FFFF, 4'hF);
      queue_request(cdq_pkg::OP_POP_BACK, 32'h0000_0000, 4'h0);
      queue_request(cdq_pkg::OP_READ_AT, 32'h0000_0000, 4'h0);
      queue_request(cdq_pkg::OP_REMOVE_AT, 32'hFFFF_FFFF, 4'hF);
      queue_request(OP_SPARE_LO, 32'hA5A5_A5A5, 4'h9);
      queue_request(OP_SPARE_HI, 32'h5A5A_5A5A, 4'h6);
      // Fill the deque from both ends, with the data extremes first.
      for (i = 0; i < cdq_pkg::CAPACITY; i++) begin
         data = (i == 0) ? 32'h0000_0000 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
         queue_request((i % 2 == 1) ? cdq_pkg::OP_PUSH_BACK : cdq_pkg::OP_PUSH_FRONT,
                       data, cdq_pkg::POS_WIDTH'($urandom));
      end
      // A push on the full deque is dropped; then the front entry is read and
      // an entry in the middle is taken out, closing the gap.
      queue_request(cdq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF, 4'h0);
      queue_request(cdq_pkg::OP_READ_AT, 32'h0000_0000, 4'hF);
      queue_request(cdq_pkg::OP_REMOVE_AT, 32'h0000_0000, 4'h7);

      // Random part, in stretches that mostly fill, mostly drain, or mix.
      // Positions usually point at a stored entry, and now and then a spare
      // code slips in as noise.
      made = 0;
      while (made < RANDOM_BEATS) begin
         phase = (made / 40) % 3;
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            op = ($urandom_range(0, 1) == 1) ? OP_SPARE_HI : OP_SPARE_LO;
         end else begin
            made++;
            if ((phase == 0 && pick < 70) || (phase == 1 && pick < 25)) begin
               op = ($urandom_range(0, 1) == 1) ? cdq_pkg::OP_PUSH_BACK
                                                : cdq_pkg::OP_PUSH_FRONT;
            end else if (phase == 2) begin
               op = cdq_pkg::OP_WIDTH'($urandom_range(cdq_pkg::OP_PUSH_FRONT,
                                                      cdq_pkg::OP_REMOVE_AT));
            end else begin
               op = cdq_pkg::OP_WIDTH'($urandom_range(cdq_pkg::OP_POP_FRONT,
                                                      cdq_pkg::OP_REMOVE_AT));
            end
         end
         if (planned_count > 0 && $urandom_range(0, 3) != 0) begin
            pos = cdq_pkg::POS_WIDTH'($urandom_range(0, planned_count - 1));
         end else begin
            pos = cdq_pkg::POS_WIDTH'($urandom_range(0, 15));
         end
         pick = $urandom_range(0, 9);
         data = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
         queue_request(op, data, pos);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Checked at the falling edge, away from the updates at the rising one.
      while (request_backlog.size() != 0 || req_tvalid || pending_answers.size() != 0) begin
         @(negedge clock);
      end
      // The block answers in the cycle after a request; a further wait lets any
      // stray beat show up.
      repeat (8) @(posedge clock);

      if (error_count == 0) begin
         $display("[circular_deque_engine_top] OK");
      end else begin
         $display("[circular_deque_engine_top] ERROR");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #1000000;
      $display("[circular_deque_engine_top] ERROR");
      $finish;
   end

endmodule
